@@ src/assert_macros.svh @@
// Assertion helpers included by the word decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked property, disabled while reset is low.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Expression that must never be true.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ src/xad_pkg.sv @@
`default_nettype none

package xad_pkg;

  // Number of channel histories kept.
  localparam int NUM_CHANNELS = 2;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int COEF_W = 11;
  localparam logic [3:0] FILTER_MAX = 4'd4;

  localparam logic signed [31:0] CLAMP_HIGH = 32'sd524272;
  localparam logic signed [31:0] CLAMP_LOW = -32'sd524288;
  localparam logic [15:0] PCM_MAX = 16'h7FFF;
  localparam logic [15:0] PCM_MIN = 16'h8000;

  // Request action codes.
  localparam logic ACT_DECODE = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic        action;
    logic        channel;
    logic [3:0]  filter_index;
    logic [3:0]  shift_amount;
    logic [15:0] nibble_word;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] pcm_first;
    logic signed [15:0] pcm_second;
    logic signed [15:0] pcm_third;
    logic signed [15:0] pcm_fourth;
  } out_rsp_t;

  // History write request: clear or write back one channel.
  typedef struct packed {
    logic            en;
    logic            clr;
    logic [CH_W-1:0] ch;
    logic [31:0]     newest;
    logic [31:0]     older;
  } hist_wr_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;
    logic load;
  } mac_op_t;

  // Coefficient applied to the newer history value.
  function automatic logic [COEF_W-1:0] coef_newer(input logic [3:0] filt);
    logic [COEF_W-1:0] k;
    case (filt)
      4'd1:    k = 11'd960;
      4'd2:    k = 11'd1840;
      4'd3:    k = 11'd1568;
      4'd4:    k = 11'd1952;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Coefficient applied to the older history value.
  function automatic logic [COEF_W-1:0] coef_older(input logic [3:0] filt);
    logic [COEF_W-1:0] k;
    case (filt)
      4'd2:    k = 11'd832;
      4'd3:    k = 11'd880;
      4'd4:    k = 11'd960;
      default: k = '0;
    endcase
    return k;
  endfunction

  // Sign-extend the nibble into bits 15:12, shift right and scale by 16.
  function automatic logic [31:0] nib_base(input logic [3:0] nib, input logic [3:0] sh);
    logic signed [15:0] v;
    v = {nib, 12'h000};
    v = v >>> sh;
    return {{12{v[15]}}, v, 4'h0};
  endfunction

  // Saturate to the 20-bit range and drop the low four bits.
  function automatic logic [15:0] clamp_pcm(input logic [31:0] v);
    logic signed [31:0] s;
    logic [15:0] r;
    s = $signed(v);
    if (s > CLAMP_HIGH) begin
      r = PCM_MAX;
    end else if (s < CLAMP_LOW) begin
      r = PCM_MIN;
    end else begin
      r = s[19:4];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/xad_mac.sv @@
`default_nettype none

// Shared multiply-accumulate unit: loads or subtracts one 32-bit wrapping product.
module xad_mac (
  input  wire logic                       clk_i,
  input  wire xad_pkg::mac_op_t           op_i,
  input  wire logic [xad_pkg::COEF_W-1:0] coef_i,
  input  wire logic [31:0]                opnd_i,
  output logic [31:0]                     acc_o
);
  import xad_pkg::*;

  logic [31:0] prod;
  logic [31:0] acc_d, acc_q;

  // Product modulo 2^32.
  assign prod = opnd_i * {{(32 - COEF_W){1'b0}}, coef_i};

  always_comb begin
    acc_d = acc_q;
    if (op_i.en) begin
      acc_d = op_i.load ? prod : (acc_q - prod);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

@@ src/xad_hist.sv @@
`default_nettype none

// Per-channel prediction history, two unclamped values per channel.
module xad_hist (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [xad_pkg::CH_W-1:0] rd_ch_i,
  output logic [31:0]                   rd_newest_o,
  output logic [31:0]                   rd_older_o,
  input  wire xad_pkg::hist_wr_t        wr_i
);
  import xad_pkg::*;

  logic [31:0] newest_q [NUM_CHANNELS];
  logic [31:0] older_q [NUM_CHANNELS];

  assign rd_newest_o = newest_q[rd_ch_i];
  assign rd_older_o = older_q[rd_ch_i];

  // Clear or write back one channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        newest_q[c] <= '0;
        older_q[c] <= '0;
      end
    end else if (wr_i.en) begin
      newest_q[wr_i.ch] <= wr_i.clr ? 32'h0 : wr_i.newest;
      older_q[wr_i.ch] <= wr_i.clr ? 32'h0 : wr_i.older;
    end
  end

endmodule

`default_nettype wire

@@ src/xa_adpcm_word_decoder.sv @@
// Four-sample ADPCM word decoder.
// A request on the in channel (in_valid_i / in_ready_o / in_req_i) carries one
// 16-bit word of four nibbles plus the filter and shift of the block header,
// or a clear action that zeroes the selected channel history. A decode gives
// one response on the out channel (out_valid_o / out_ready_i / out_rsp_o)
// with four saturated PCM samples, low nibble first. Clear actions and
// requests for a channel that does not exist give no response.
// One multiply-accumulate unit is reused for every prediction: each nibble
// passes the two products and the update (ST_MUL_OLD, ST_MUL_NEW, ST_APPLY),
// and after the fourth nibble ST_FINISH presents the response. Pass-through
// filters (5 to 15) clamp each nibble in ST_PASS without the multiplier.
// A clear completes in its acceptance cycle. in_ready_o is high only while
// the sequencer is idle. The response sits in an output register, so a new
// request is taken while an earlier response still waits; if the receiver
// still stalls when the next decode finishes, the sequencer holds there.
// Reset zeroes every channel history and empties the output register.
`default_nettype none

module xa_adpcm_word_decoder (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire xad_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output xad_pkg::out_rsp_t      out_rsp_o
);
  import xad_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MUL_OLD = 6'b000010,
    ST_MUL_NEW = 6'b000100,
    ST_APPLY   = 6'b001000,
    ST_PASS    = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_e;

  state_e state_d, state_q;
  logic [1:0] cnt_d, cnt_q;
  in_req_t req_d, req_q;
  logic [31:0] p1_d, p1_q;
  logic [31:0] p2_d, p2_q;
  logic [15:0] samp_q [4];
  logic out_valid_d, out_valid_q;
  out_rsp_t out_d, out_q;

  logic in_acc, out_acc, ch_ok, is_pred, dec_start;
  logic [CH_W-1:0] in_ch, req_ch;
  logic [31:0] hist_newest, hist_older;
  hist_wr_t hist_wr;
  mac_op_t mac_op;
  logic [COEF_W-1:0] mac_coef;
  logic [31:0] mac_opnd, mac_acc;
  logic [15:0] word_sh;
  logic [31:0] base, pred_val;
  logic samp_we;
  logic [15:0] samp_wd;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc = in_valid_i && in_ready_o;
  assign out_acc = out_valid_q && out_ready_i;
  assign ch_ok = (32'(in_req_i.channel) < NUM_CHANNELS);
  assign dec_start = in_acc && ch_ok && (in_req_i.action == ACT_DECODE);
  assign in_ch = CH_W'(in_req_i.channel);
  assign req_ch = CH_W'(req_q.channel);
  assign is_pred = (req_q.filter_index <= FILTER_MAX);

  // Current nibble and its scaled value.
  assign word_sh = req_q.nibble_word >> {cnt_q, 2'b00};
  assign base = nib_base(word_sh[3:0], req_q.shift_amount);
  assign pred_val = base - 32'($signed(mac_acc) >>> 10);

  xad_hist u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_ch_i     (in_ch),
    .rd_newest_o (hist_newest),
    .rd_older_o  (hist_older),
    .wr_i        (hist_wr)
  );

  xad_mac u_mac (
    .clk_i  (clk_i),
    .op_i   (mac_op),
    .coef_i (mac_coef),
    .opnd_i (mac_opnd),
    .acc_o  (mac_acc)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    req_d = req_q;
    p1_d = p1_q;
    p2_d = p2_q;
    hist_wr = '0;
    mac_op = '0;
    mac_coef = coef_older(req_q.filter_index);
    mac_opnd = p2_q;
    samp_we = 1'b0;
    samp_wd = clamp_pcm(base);
    out_valid_d = out_valid_q && !out_acc;
    out_d = out_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_acc && ch_ok) begin
          if (in_req_i.action == ACT_CLEAR) begin
            hist_wr.en = 1'b1;
            hist_wr.clr = 1'b1;
            hist_wr.ch = in_ch;
          end else begin
            req_d = in_req_i;
            p1_d = hist_newest;
            p2_d = hist_older;
            state_d = (in_req_i.filter_index <= FILTER_MAX) ? ST_MUL_OLD : ST_PASS;
          end
        end
      end
      ST_MUL_OLD: begin
        mac_op.en = 1'b1;
        mac_op.load = 1'b1;
        state_d = ST_MUL_NEW;
      end
      ST_MUL_NEW: begin
        mac_op.en = 1'b1;
        mac_coef = coef_newer(req_q.filter_index);
        mac_opnd = p1_q;
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        samp_we = 1'b1;
        samp_wd = clamp_pcm(pred_val);
        p2_d = p1_q;
        p1_d = pred_val;
        cnt_d = cnt_q + 2'd1;
        state_d = (cnt_q == 2'd3) ? ST_FINISH : ST_MUL_OLD;
      end
      ST_PASS: begin
        samp_we = 1'b1;
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d.pcm_first = samp_q[0];
          out_d.pcm_second = samp_q[1];
          out_d.pcm_third = samp_q[2];
          out_d.pcm_fourth = samp_q[3];
          hist_wr.en = is_pred;
          hist_wr.ch = req_ch;
          hist_wr.newest = p1_q;
          hist_wr.older = p2_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    p1_q <= p1_d;
    p2_q <= p2_d;
    out_q <= out_d;
    if (samp_we) begin
      samp_q[cnt_q] <= samp_wd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o = out_q;

`include "assert_macros.svh"

  // A decode request for an existing channel starts work.
  `ASSERT_PROP(a_decode_busy, clk_i, rst_ni, dec_start |=> !in_ready_o)
  // The nibble counter is back at zero whenever the sequencer idles.
  `ASSERT_NEVER(a_idle_cnt, clk_i, rst_ni, (state_q == ST_IDLE) && (cnt_q != 2'd0))
  // A response appears only out of the finishing step.
  `ASSERT_PROP(a_rsp_source, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_FINISH))

endmodule

`default_nettype wire
